>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file of the window sender.
// Each macro expects signals named clk and arst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SWSC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SWSC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/swsc_pkg.sv
// Shared types, codes and helpers for the sliding-window sender control unit.
// No dependencies.
`timescale 1ns / 1ps

package swsc_pkg;

	// Default sizing
	localparam int SLOTS_DEF       = 4;
	localparam int WINDOW_DEF      = 1;
	localparam int QUEUE_DEPTH_DEF = 16;

	// Command codes
	localparam logic [1:0] CMD_NEW   = 2'd0;
	localparam logic [1:0] CMD_ACK   = 2'd1;
	localparam logic [1:0] CMD_TIMER = 2'd2;

	// Action codes
	localparam logic [1:0] ACT_XMIT   = 2'd0;
	localparam logic [1:0] ACT_STOP   = 2'd1;
	localparam logic [1:0] ACT_REFUSE = 2'd2;

	typedef struct packed {
		logic [1:0]  command;
		logic [7:0]  packet_handle;
		logic [15:0] ack_number;
		logic        is_nak;
		logic        checksum_ok;
	} swsc_in_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] frame_seq;
		logic [7:0]  frame_handle;
		logic        last;
	} swsc_out_t;

	typedef struct packed {
		logic push;
		logic pop;
	} q_ctrl_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_NAK_RESEND,
		ST_NAK_RETIRE,
		ST_ACK_SLIDE,
		ST_SEND_CHK,
		ST_SEND_EMIT,
		ST_STOP_CHK,
		ST_TIMER,
		ST_FINISH
	} state_t;

	// Slot of (base slot + offset) modulo the slot count; offset stays below sixteen
	function automatic logic [4:0] slot_add(input logic [4:0] s, input logic [3:0] d,
			input logic [4:0] n);
		logic [4:0] v;
		v = s + {1'b0, d};
		for (int i = 0; i < 4; i++) begin
			if (v >= n) begin
				v = v - n;
			end
		end
		return v;
	endfunction

endpackage

>>> rtl/core/swsc_queue.sv
// Pending-packet queue: handle memory with head/tail pointers and fill count.
// Depends on swsc_pkg for the control and status structs.
`timescale 1ns / 1ps

module swsc_queue #(
	parameter int DEPTH = swsc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  swsc_pkg::q_ctrl_t ctrl,
	input  logic [7:0]        wr_data,
	output logic [7:0]        rd_data,
	output swsc_pkg::q_stat_t stat
);
	import swsc_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int FW = $clog2(DEPTH + 1);

	logic [7:0]    mem [DEPTH];
	logic [PW-1:0] head_q;
	logic [PW-1:0] tail_q;
	logic [FW-1:0] fill_q;
	logic [7:0]    rd_q;

	// Store on push, registered read of the head entry every cycle
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			mem[tail_q] <= wr_data;
		end
		rd_q <= mem[head_q];
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
		end else begin
			if (ctrl.push) begin
				tail_q <= (tail_q == PW'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
			end
			if (ctrl.pop) begin
				head_q <= (head_q == PW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
			end
			if (ctrl.push && !ctrl.pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (ctrl.pop && !ctrl.push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	assign rd_data    = rd_q;
	assign stat.full  = (fill_q == FW'(DEPTH));
	assign stat.empty = (fill_q == '0);

endmodule

>>> rtl/core/sliding_window_sender_control_unit.sv
// Sliding-window sender control: one event at a time through a small sequencer
// that drives one shared 16-bit sequence adder. Depends on swsc_pkg, swsc_queue.
// Results leave from an output register; the receiver cannot stall.
// Reset (arst_n low) empties the window and the queue and clears all acked flags.
`timescale 1ns / 1ps

module sliding_window_sender_control_unit #(
	parameter int SLOTS       = swsc_pkg::SLOTS_DEF,
	parameter int WINDOW      = swsc_pkg::WINDOW_DEF,
	parameter int QUEUE_DEPTH = swsc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  swsc_pkg::swsc_in_t  req,
	output swsc_pkg::swsc_out_t rsp,
	output logic                strobe
);
	import swsc_pkg::*;

	localparam int SW = $clog2(SLOTS);
	localparam int CW = $clog2(WINDOW + 1);

	state_t state_q, state_d;
	swsc_in_t req_q, req_d;
	logic [15:0] base_q, base_d;
	logic [15:0] next_q, next_d;
	logic [CW-1:0] outs_q, outs_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [SW-1:0] base_slot_q, base_slot_d;
	logic [SW-1:0] next_slot_q, next_slot_d;
	logic [SW-1:0] idx_q, idx_d;
	logic moved_q, moved_d;
	logic stop_q, stop_d;
	logic in_q, in_d;

	logic [SLOTS-1:0] acked_q;
	logic [7:0] handle_q [SLOTS];

	swsc_out_t hold_q;
	logic hold_v_q;
	swsc_out_t rsp_q;
	logic strobe_q;

	// Shared sequence adder
	logic [15:0] op_a, op_b, sum;
	logic cin;

	// Per-cycle controls
	logic emit, flush;
	swsc_out_t emit_res;
	logic mark_en, clr_en, hwr_en;
	logic [SW-1:0] mark_idx, clr_idx;
	q_ctrl_t q_ctrl;
	q_stat_t q_stat;
	logic [7:0] q_rd;

	// Window checks on the adder result
	logic in_win, nxt_in;
	logic [3:0] nxt_off;

	function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
		return (s == SW'(SLOTS - 1)) ? '0 : s + 1'b1;
	endfunction

	swsc_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (q_ctrl),
		.wr_data(req_q.packet_handle),
		.rd_data(q_rd),
		.stat   (q_stat)
	);

	// Select adder operands by step
	always_comb begin
		op_a = '0;
		op_b = '0;
		cin  = 1'b0;
		case (state_q)
			ST_DECODE: begin
				op_a = req_q.ack_number;
				op_b = ~base_q;
				cin  = 1'b1;
			end
			ST_NAK_RESEND: begin
				op_a = req_q.ack_number;
				cin  = 1'b1;
			end
			ST_SEND_EMIT: begin
				op_a = next_q;
				cin  = 1'b1;
			end
			ST_ACK_SLIDE, ST_NAK_RETIRE: begin
				op_a = base_q;
				cin  = 1'b1;
			end
			ST_TIMER: begin
				op_a = base_q;
				op_b = 16'(cnt_q);
			end
			default: begin
				op_a = '0;
			end
		endcase
	end

	assign sum = op_a + op_b + 16'(cin);

	// Offset checks against the current window span
	assign in_win  = (sum < 16'(outs_q));
	assign nxt_in  = (outs_q != '0) && ((sum == 16'hFFFF) || (sum < 16'(outs_q) - 16'd1));
	assign nxt_off = (sum == 16'hFFFF) ? 4'd0 : sum[3:0] + 4'd1;

	// Sequencer: next state and step controls
	always_comb begin
		state_d     = state_q;
		req_d       = req_q;
		base_d      = base_q;
		next_d      = next_q;
		outs_d      = outs_q;
		cnt_d       = cnt_q;
		base_slot_d = base_slot_q;
		next_slot_d = next_slot_q;
		idx_d       = idx_q;
		moved_d     = moved_q;
		stop_d      = stop_q;
		in_d        = in_q;
		emit        = 1'b0;
		emit_res    = '0;
		flush       = 1'b0;
		mark_en     = 1'b0;
		mark_idx    = '0;
		clr_en      = 1'b0;
		clr_idx     = base_slot_q;
		hwr_en      = 1'b0;
		q_ctrl      = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					req_d   = req;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				case (req_q.command)
					CMD_NEW: begin
						if (q_stat.full) begin
							emit                  = 1'b1;
							emit_res.action       = ACT_REFUSE;
							emit_res.frame_handle = req_q.packet_handle;
							state_d               = ST_FINISH;
						end else begin
							q_ctrl.push = 1'b1;
							stop_d      = 1'b0;
							state_d     = ST_SEND_CHK;
						end
					end
					CMD_ACK: begin
						if (!req_q.checksum_ok) begin
							state_d = ST_FINISH;
						end else if (req_q.is_nak) begin
							in_d   = in_win;
							cnt_d  = CW'(sum[3:0] + 4'd1);
							idx_d  = SW'(slot_add(5'(base_slot_q), nxt_off, 5'(SLOTS)));
							stop_d = 1'b1;
							if (nxt_in) begin
								state_d = ST_NAK_RESEND;
							end else if (in_win) begin
								state_d = ST_NAK_RETIRE;
							end else begin
								state_d = ST_STOP_CHK;
							end
						end else if (in_win) begin
							mark_en  = 1'b1;
							mark_idx = SW'(slot_add(5'(base_slot_q), sum[3:0], 5'(SLOTS)));
							moved_d  = 1'b0;
							stop_d   = 1'b1;
							state_d  = ST_ACK_SLIDE;
						end else begin
							state_d = ST_FINISH;
						end
					end
					CMD_TIMER: begin
						cnt_d   = '0;
						idx_d   = base_slot_q;
						state_d = ST_TIMER;
					end
					default: begin
						state_d = ST_FINISH;
					end
				endcase
			end
			ST_NAK_RESEND: begin
				emit                  = 1'b1;
				emit_res.action       = ACT_XMIT;
				emit_res.frame_seq    = sum;
				emit_res.frame_handle = handle_q[idx_q];
				state_d               = in_q ? ST_NAK_RETIRE : ST_STOP_CHK;
			end
			ST_NAK_RETIRE: begin
				// Retire the base frame, up to and including the named one
				clr_en      = 1'b1;
				outs_d      = outs_q - 1'b1;
				base_d      = sum;
				base_slot_d = slot_inc(base_slot_q);
				cnt_d       = cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					state_d = ST_SEND_CHK;
				end
			end
			ST_ACK_SLIDE: begin
				// Slide the base over acked slots
				if (acked_q[base_slot_q] && (outs_q != '0)) begin
					clr_en      = 1'b1;
					outs_d      = outs_q - 1'b1;
					base_d      = sum;
					base_slot_d = slot_inc(base_slot_q);
					moved_d     = 1'b1;
				end else begin
					state_d = moved_q ? ST_SEND_CHK : ST_STOP_CHK;
				end
			end
			ST_SEND_CHK: begin
				if ((outs_q < CW'(WINDOW)) && !q_stat.empty) begin
					state_d = ST_SEND_EMIT;
				end else begin
					state_d = stop_q ? ST_STOP_CHK : ST_FINISH;
				end
			end
			ST_SEND_EMIT: begin
				// Move the queue head out as a new frame
				q_ctrl.pop            = 1'b1;
				emit                  = 1'b1;
				emit_res.action       = ACT_XMIT;
				emit_res.frame_seq    = next_q;
				emit_res.frame_handle = q_rd;
				clr_en                = 1'b1;
				clr_idx               = next_slot_q;
				hwr_en                = 1'b1;
				outs_d                = outs_q + 1'b1;
				next_d                = sum;
				next_slot_d           = slot_inc(next_slot_q);
				state_d               = ST_SEND_CHK;
			end
			ST_STOP_CHK: begin
				if ((outs_q == '0) && q_stat.empty) begin
					emit            = 1'b1;
					emit_res.action = ACT_STOP;
				end
				state_d = ST_FINISH;
			end
			ST_TIMER: begin
				// Resend every unacked frame, oldest first
				if (cnt_q < outs_q) begin
					if (!acked_q[idx_q]) begin
						emit                  = 1'b1;
						emit_res.action       = ACT_XMIT;
						emit_res.frame_seq    = sum;
						emit_res.frame_handle = handle_q[idx_q];
					end
					cnt_d = cnt_q + 1'b1;
					idx_d = slot_inc(idx_q);
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				flush   = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold sequencer and window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			req_q       <= '0;
			base_q      <= '0;
			next_q      <= '0;
			outs_q      <= '0;
			cnt_q       <= '0;
			base_slot_q <= '0;
			next_slot_q <= '0;
			idx_q       <= '0;
			moved_q     <= 1'b0;
			stop_q      <= 1'b0;
			in_q        <= 1'b0;
		end else begin
			state_q     <= state_d;
			req_q       <= req_d;
			base_q      <= base_d;
			next_q      <= next_d;
			outs_q      <= outs_d;
			cnt_q       <= cnt_d;
			base_slot_q <= base_slot_d;
			next_slot_q <= next_slot_d;
			idx_q       <= idx_d;
			moved_q     <= moved_d;
			stop_q      <= stop_d;
			in_q        <= in_d;
		end
	end

	// Acked flags per slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acked_q <= '0;
		end else begin
			if (clr_en) begin
				acked_q[clr_idx] <= 1'b0;
			end
			if (mark_en) begin
				acked_q[mark_idx] <= 1'b1;
			end
		end
	end

	// Handle per slot, written when a frame goes out
	always_ff @(posedge clk) begin
		if (hwr_en) begin
			handle_q[next_slot_q] <= q_rd;
		end
	end

	// Result payload: hold one back so the final one can carry last
	always_ff @(posedge clk) begin
		if (emit) begin
			hold_q <= emit_res;
			rsp_q  <= hold_q;
		end else if (flush) begin
			rsp_q <= '{action: hold_q.action, frame_seq: hold_q.frame_seq,
				frame_handle: hold_q.frame_handle, last: 1'b1};
		end
	end

	// Result strobe and hold-valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (emit) begin
				strobe_q <= hold_v_q;
				hold_v_q <= 1'b1;
			end else if (flush) begin
				strobe_q <= hold_v_q;
				hold_v_q <= 1'b0;
			end
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign rsp    = rsp_q;
	assign strobe = strobe_q;

endmodule

>>> rtl/core/swsc_chk.sv
// Port-level checker for the sliding-window sender control unit, with its bind.
// Depends on swsc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module swsc_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input swsc_pkg::swsc_out_t rsp,
	input logic                strobe
);
	import swsc_pkg::*;

	// An accepted transfer makes the unit busy and shows no result yet
	`SWSC_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !strobe, "no busy after accept")

	// A refusal is the only result of its event and carries no sequence number
	`SWSC_ASSERT_SAME(a_refuse_form, strobe && (rsp.action == ACT_REFUSE),
		rsp.last && (rsp.frame_seq == 16'd0), "malformed refuse result")

	// A stop result ends its event and carries no frame
	`SWSC_ASSERT_SAME(a_stop_form, strobe && (rsp.action == ACT_STOP),
		rsp.last && (rsp.frame_seq == 16'd0) && (rsp.frame_handle == 8'd0),
		"malformed stop result")

	// The final result of an event is followed by a quiet cycle
	`SWSC_ASSERT_NEXT(a_last_gap, strobe && rsp.last, !strobe, "result right after last")

	// Only defined actions appear
	`SWSC_ASSERT_SAME(a_action_code, strobe,
		(rsp.action == ACT_XMIT) || (rsp.action == ACT_STOP) || (rsp.action == ACT_REFUSE),
		"undefined action code")

endmodule

bind sliding_window_sender_control_unit swsc_chk u_swsc_chk (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.rsp   (rsp),
	.strobe(strobe)
);
